FILE: design/qpn_pkg.sv
// Shared types and constants for the normalized quaternion product pipeline.
// No dependencies; imported by every design module.
package qpn_pkg;

  localparam int CompW     = 32;  // Q16.16 component width
  localparam int TermW     = 48;  // Q32.32 product shifted right by 16
  localparam int SumW      = 50;  // four terms summed exactly
  localparam int SqW       = 64;  // square and sum of squares
  localparam int RootSteps = 32;  // one root bit per stage
  localparam int QuoW      = 17;  // quotient magnitude is at most 65536
  localparam int DivW      = 48;  // dividend is a 32-bit magnitude shifted by 16

  typedef logic [3:0][CompW-1:0] quat_t;

  // Per-request data that rides alongside the root and divide stages
  typedef struct packed {
    logic [3:0]            neg;
    logic                  degen;
    logic [3:0][CompW-1:0] mag;
  } side_t;

  function automatic logic signed [SumW-1:0] sx_term(input logic signed [TermW-1:0] v);
    return {{(SumW-TermW){v[TermW-1]}}, v};
  endfunction

endpackage

FILE: design/qpn_product.sv
// Hamilton product b*a: sixteen 32x32 products, then four saturated sums.
// Depends on qpn_pkg.
module qpn_product import qpn_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  input  logic  in_vld,
  input  quat_t a,
  input  quat_t b,
  output logic  p_vld,
  output quat_t p
);

  localparam logic signed [SumW-1:0] SatHi = SumW'(64'sd2147483647);
  localparam logic signed [SumW-1:0] SatLo = SumW'(-64'sd2147483648);

  logic signed [TermW-1:0] term_r [4][4];
  logic signed [TermW-1:0] term_nxt [4][4];
  logic signed [SumW-1:0]  sum [4];
  logic                    s1_vld_r;
  logic                    s2_vld_r;
  quat_t                   p_r;
  quat_t                   p_nxt;

  // Exact products, floor shift by 16 is the upper bits
  always_comb begin
    logic signed [63:0] prod;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        prod = $signed({{32{b[i][31]}}, b[i]}) * $signed({{32{a[j][31]}}, a[j]});
        term_nxt[i][j] = prod[63:16];
      end
    end
  end

  // Component sums (index 0..3 = x, y, z, w)
  always_comb begin
    sum[0] = sx_term(term_r[3][0]) + sx_term(term_r[0][3])
           + sx_term(term_r[1][2]) - sx_term(term_r[2][1]);
    sum[1] = sx_term(term_r[3][1]) + sx_term(term_r[1][3])
           + sx_term(term_r[2][0]) - sx_term(term_r[0][2]);
    sum[2] = sx_term(term_r[3][2]) + sx_term(term_r[2][3])
           + sx_term(term_r[0][1]) - sx_term(term_r[1][0]);
    sum[3] = sx_term(term_r[3][3]) - sx_term(term_r[0][0])
           - sx_term(term_r[1][1]) - sx_term(term_r[2][2]);
    for (int i = 0; i < 4; i++) begin
      if (sum[i] > SatHi) begin
        p_nxt[i] = 32'h7fff_ffff;
      end else if (sum[i] < SatLo) begin
        p_nxt[i] = 32'h8000_0000;
      end else begin
        p_nxt[i] = sum[i][CompW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      term_r <= term_nxt;
      p_r    <= p_nxt;
    end
  end

  assign p_vld = s2_vld_r;
  assign p     = p_r;

endmodule

FILE: design/qpn_scale.sv
// Magnitudes, block shift to bring the largest to at least 2^30, squares and sum of squares.
// Depends on qpn_pkg.
module qpn_scale import qpn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              p_vld,
  input  quat_t             p,
  output logic              s_vld,
  output logic [SqW-1:0]    s_sum,
  output side_t             s_side
);

  logic [3:0]       vld_r;
  side_t            m_r, t_side_r, sh_r, sq_side_r, sum_side_r;
  logic [CompW-1:0] max_nxt, max_r;
  logic [4:0]       sh_nxt, sh_amt_r;
  logic [SqW-1:0]   sq_r [4];
  logic [SqW+1:0]   total;
  logic [SqW-1:0]   sum_r;
  side_t            m_nxt, sh_nxt_side;

  // Stage A: sign and magnitude, largest magnitude
  always_comb begin
    logic [CompW-1:0] m01, m23;
    m_nxt = '0;
    for (int i = 0; i < 4; i++) begin
      m_nxt.neg[i] = p[i][CompW-1];
      m_nxt.mag[i] = p[i][CompW-1] ? CompW'(-p[i]) : p[i];
    end
    m01 = (m_nxt.mag[0] > m_nxt.mag[1]) ? m_nxt.mag[0] : m_nxt.mag[1];
    m23 = (m_nxt.mag[2] > m_nxt.mag[3]) ? m_nxt.mag[2] : m_nxt.mag[3];
    max_nxt = (m01 > m23) ? m01 : m23;
    m_nxt.degen = (max_nxt == '0);
  end

  // Stage B: shift that puts the top bit of the largest at bit 30 or above
  always_comb begin
    logic [4:0] msb;
    msb = '0;
    for (int k = 0; k < CompW; k++) begin
      if (max_r[k]) msb = 5'(k);
    end
    sh_nxt = (msb >= 5'd30) ? 5'd0 : 5'd30 - msb;
  end

  // Stage C: apply the shift
  always_comb begin
    sh_nxt_side = t_side_r;
    for (int i = 0; i < 4; i++) begin
      sh_nxt_side.mag[i] = t_side_r.mag[i] << sh_amt_r;
    end
  end

  // Stage E: saturated sum of squares
  assign total = {2'b0, sq_r[0]} + {2'b0, sq_r[1]} + {2'b0, sq_r[2]} + {2'b0, sq_r[3]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[2:0], p_vld};
    end
  end

  logic sum_vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_vld_r <= 1'b0;
    end else if (adv) begin
      sum_vld_r <= vld_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_r      <= m_nxt;
      max_r    <= max_nxt;
      t_side_r <= m_r;
      sh_amt_r <= sh_nxt;
      sh_r     <= sh_nxt_side;
      // Stage D: squares
      for (int i = 0; i < 4; i++) begin
        sq_r[i] <= SqW'(sh_r.mag[i]) * SqW'(sh_r.mag[i]);
      end
      sq_side_r  <= sh_r;
      sum_r      <= total[SqW+1:SqW] != 2'b0 ? {SqW{1'b1}} : total[SqW-1:0];
      sum_side_r <= sq_side_r;
    end
  end

  assign s_vld  = sum_vld_r;
  assign s_sum  = sum_r;
  assign s_side = sum_side_r;

endmodule

FILE: design/qpn_isqrt.sv
// Pipelined integer square root of a 64-bit value, one root bit per stage.
// Depends on qpn_pkg.
module qpn_isqrt import qpn_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_vld,
  input  logic [SqW-1:0]   in_val,
  input  side_t            in_side,
  output logic             out_vld,
  output logic [CompW-1:0] out_root,
  output side_t            out_side
);

  logic [SqW-1:0] rem_r  [RootSteps];
  logic [SqW-1:0] root_r [RootSteps];
  side_t          side_r [RootSteps];
  logic           vld_r  [RootSteps];

  for (genvar g = 0; g < RootSteps; g++) begin : g_step
    logic [SqW-1:0] rem_in, root_in, bitv, trial;
    logic           vld_in;
    side_t          side_in;

    if (g == 0) begin : g_first
      assign rem_in  = in_val;
      assign root_in = '0;
      assign vld_in  = in_vld;
      assign side_in = in_side;
    end else begin : g_next
      assign rem_in  = rem_r[g-1];
      assign root_in = root_r[g-1];
      assign vld_in  = vld_r[g-1];
      assign side_in = side_r[g-1];
    end

    assign bitv  = SqW'(1) << (SqW - 2 - 2*g);
    assign trial = root_in + bitv;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (adv) begin
        vld_r[g] <= vld_in;
      end
    end

    // Restoring step: subtract trial when it fits
    always_ff @(posedge clk) begin
      if (adv) begin
        side_r[g] <= side_in;
        if (rem_in >= trial) begin
          rem_r[g]  <= rem_in - trial;
          root_r[g] <= (root_in >> 1) + bitv;
        end else begin
          rem_r[g]  <= rem_in;
          root_r[g] <= root_in >> 1;
        end
      end
    end
  end

  assign out_vld  = vld_r[RootSteps-1] & (rem_r[RootSteps-1] == rem_r[RootSteps-1]);
  assign out_root = root_r[RootSteps-1][CompW-1:0];
  assign out_side = side_r[RootSteps-1];

endmodule

FILE: design/qpn_divide.sv
// Four-lane pipelined restoring divide: (mag << 16) / root, one quotient bit per stage.
// Depends on qpn_pkg.
module qpn_divide import qpn_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  in_vld,
  input  logic [CompW-1:0]      in_root,
  input  side_t                 in_side,
  output logic                  out_vld,
  output logic [3:0][QuoW-1:0]  out_quo,
  output logic [3:0]            out_neg,
  output logic                  out_degen
);

  logic [3:0][DivW-1:0] rem_r  [QuoW];
  logic [3:0][QuoW-1:0] quo_r  [QuoW];
  logic [CompW-1:0]     den_r  [QuoW];
  logic [3:0]           neg_r  [QuoW];
  logic                 dgn_r  [QuoW];
  logic                 vld_r  [QuoW];

  for (genvar g = 0; g < QuoW; g++) begin : g_step
    localparam int Kb = QuoW - 1 - g;
    logic [3:0][DivW-1:0] rem_in;
    logic [3:0][QuoW-1:0] quo_in;
    logic [CompW-1:0]     den_in;
    logic [3:0]           neg_in;
    logic                 dgn_in, vld_in;
    logic [DivW:0]        dsh;

    if (g == 0) begin : g_first
      for (genvar l = 0; l < 4; l++) begin : g_lane
        assign rem_in[l] = {in_side.mag[l], 16'b0};
      end
      assign quo_in = '0;
      assign den_in = in_root;
      assign neg_in = in_side.neg;
      assign dgn_in = in_side.degen;
      assign vld_in = in_vld;
    end else begin : g_next
      assign rem_in = rem_r[g-1];
      assign quo_in = quo_r[g-1];
      assign den_in = den_r[g-1];
      assign neg_in = neg_r[g-1];
      assign dgn_in = dgn_r[g-1];
      assign vld_in = vld_r[g-1];
    end

    assign dsh = (DivW+1)'(den_in) << Kb;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (adv) begin
        vld_r[g] <= vld_in;
      end
    end

    // One quotient bit per lane
    always_ff @(posedge clk) begin
      if (adv) begin
        den_r[g] <= den_in;
        neg_r[g] <= neg_in;
        dgn_r[g] <= dgn_in;
        for (int l = 0; l < 4; l++) begin
          if ({1'b0, rem_in[l]} >= dsh) begin
            rem_r[g][l] <= DivW'({1'b0, rem_in[l]} - dsh);
            quo_r[g][l] <= quo_in[l] | (QuoW'(1) << Kb);
          end else begin
            rem_r[g][l] <= rem_in[l];
            quo_r[g][l] <= quo_in[l];
          end
        end
      end
    end
  end

  assign out_vld   = vld_r[QuoW-1];
  assign out_quo   = quo_r[QuoW-1];
  assign out_neg   = neg_r[QuoW-1];
  assign out_degen = dgn_r[QuoW-1];

endmodule

FILE: design/quaternion_product_normalize.sv
// Top level of the normalized quaternion product pipeline.
// Depends on qpn_pkg, qpn_product, qpn_scale, qpn_isqrt, qpn_divide.
//
// Usage:
//   Input channel (in_valid/in_ready) carries two quaternions a and b,
//   each x, y, z, w in signed Q16.16. The result channel (out_valid/
//   out_ready) returns b*a divided by its length, in Q16.16, with
//   out_degenerate set and all components zero when the product is zero.
//   Throughput: one request per clock when the receiver keeps up.
//   The request passes through the product, scale, square root and divide
//   stages, then an output register. The square root, one bit per stage,
//   has the most stages.
//   Every stage moves on one common advance signal: when out_valid is high
//   and out_ready is low the whole pipe holds, in_ready drops, and no
//   request is lost or repeated. Bubbles travel as cleared valid bits.
//   Reset (rst_n low, synchronous) clears all valid bits; the pipe is
//   empty and ready on the next cycle. No state is kept between requests.
module quaternion_product_normalize import qpn_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [CompW-1:0] in_a_x,
  input  logic signed [CompW-1:0] in_a_y,
  input  logic signed [CompW-1:0] in_a_z,
  input  logic signed [CompW-1:0] in_a_w,
  input  logic signed [CompW-1:0] in_b_x,
  input  logic signed [CompW-1:0] in_b_y,
  input  logic signed [CompW-1:0] in_b_z,
  input  logic signed [CompW-1:0] in_b_w,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [CompW-1:0] out_r_x,
  output logic signed [CompW-1:0] out_r_y,
  output logic signed [CompW-1:0] out_r_z,
  output logic signed [CompW-1:0] out_r_w,
  output logic                    out_degenerate
);

  logic                 adv;
  quat_t                a, b, p;
  logic                 p_vld, s_vld, q_vld, d_vld;
  logic [SqW-1:0]       s_sum;
  side_t                s_side, q_side;
  logic [CompW-1:0]     q_root;
  logic [3:0][QuoW-1:0] d_quo;
  logic [3:0]           d_neg;
  logic                 d_degen;
  logic                 out_valid_r;
  quat_t                r_r, r_nxt;
  logic                 degen_r;

  // Whole pipe advances unless a finished result is stuck
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  assign a = {in_a_w, in_a_z, in_a_y, in_a_x};
  assign b = {in_b_w, in_b_z, in_b_y, in_b_x};

  qpn_product u_product (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .in_vld (in_valid),
    .a      (a),
    .b      (b),
    .p_vld  (p_vld),
    .p      (p)
  );

  qpn_scale u_scale (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .p_vld  (p_vld),
    .p      (p),
    .s_vld  (s_vld),
    .s_sum  (s_sum),
    .s_side (s_side)
  );

  qpn_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (s_vld),
    .in_val   (s_sum),
    .in_side  (s_side),
    .out_vld  (q_vld),
    .out_root (q_root),
    .out_side (q_side)
  );

  qpn_divide u_divide (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_vld    (q_vld),
    .in_root   (q_root),
    .in_side   (q_side),
    .out_vld   (d_vld),
    .out_quo   (d_quo),
    .out_neg   (d_neg),
    .out_degen (d_degen)
  );

  // Restore sign; zero product forces zeros
  always_comb begin
    logic [CompW-1:0] mag32;
    for (int i = 0; i < 4; i++) begin
      mag32 = CompW'(d_quo[i]);
      if (d_degen) begin
        r_nxt[i] = '0;
      end else begin
        r_nxt[i] = d_neg[i] ? CompW'(-mag32) : mag32;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_r     <= r_nxt;
      degen_r <= d_degen;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_r_x        = r_r[0];
  assign out_r_y        = r_r[1];
  assign out_r_z        = r_r[2];
  assign out_r_w        = r_r[3];
  assign out_degenerate = degen_r;

endmodule
